// File: rtl/pli_pkg.sv
// Package for the piecewise linear interpolator: widths, codes and the
// operand/result structs shared by the sequencer and the mul/div unit.
// No dependencies.
package pli_pkg;

    localparam int DATA_W     = 32;                     // Q16.16 word
    localparam int FRAC_BITS  = 16;                     // binary point, format only
    localparam int MAX_POINTS = 16;                     // table depth
    localparam int PTR_W      = $clog2(MAX_POINTS);     // table address
    localparam int IDX_W      = 4;                      // point_index field
    localparam int CNT_W      = 5;                      // point_count field
    localparam int STATUS_W   = 3;
    localparam int ENTRY_W    = 2 * DATA_W;             // {radius, value}

    // mul/div unit: |dv| < 2^32 needs 33 bits, quotient never exceeds |dv|
    localparam int MAG_W      = DATA_W + 1;
    localparam int Q_W        = MAG_W;
    localparam int ALU_W      = DATA_W + 2;
    localparam int MUL_STEPS  = DATA_W;
    localparam int DIV_STEPS  = Q_W;
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOSEG   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZEROW   = 3'd4;

    typedef logic signed [DATA_W-1:0] fix_t;

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  mag;    // |v1 - v0|
        logic [DATA_W-1:0] dx;     // x - r0
        logic [DATA_W-1:0] span;   // r1 - r0, nonzero
    } mdu_op_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;      // round(mag * dx / span), ties away
    } mdu_res_t;

endpackage

// File: rtl/pli_if.sv
// Channel interfaces of the piecewise linear interpolator: request,
// response and point-count write channel. Depends on pli_pkg.
interface pli_req_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [pli_pkg::IDX_W-1:0]     point_index;
    logic signed [pli_pkg::DATA_W-1:0] point_radius;
    logic signed [pli_pkg::DATA_W-1:0] point_value;
    logic signed [pli_pkg::DATA_W-1:0] x;

    modport source (output valid, op, point_index, point_radius, point_value, x,
                    input ready);
    modport sink   (input valid, op, point_index, point_radius, point_value, x,
                    output ready);
endinterface

interface pli_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [pli_pkg::DATA_W-1:0] value;
    logic [pli_pkg::STATUS_W-1:0]      status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

interface pli_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [pli_pkg::CNT_W-1:0]  point_count;

    modport source (output valid, point_count, input ready);
    modport sink   (input valid, point_count, output ready);
endinterface

// File: rtl/pli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/pli_mdu.sv
// Iterative multiply-then-divide unit around one shared 34-bit adder:
// shift-add multiply, restoring divide, then a rounding compare.
// Depends on pli_pkg.
module pli_mdu (
    input  logic             clk,
    input  logic             rst_n,
    input  pli_pkg::mdu_op_t op,
    output pli_pkg::mdu_res_t res
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_DIV,
        M_RND
    } mstate_t;

    mstate_t                     state_reg;
    logic [pli_pkg::STEP_W-1:0]  cnt_reg;
    logic [pli_pkg::MAG_W-1:0]   mag_reg;
    logic [pli_pkg::DATA_W-1:0]  span_reg;
    logic [pli_pkg::MAG_W-1:0]   hi_reg;     // product high part
    logic [pli_pkg::DATA_W-1:0]  lo_reg;     // multiplier / product low part
    logic [pli_pkg::DATA_W-1:0]  rem_reg;
    logic [pli_pkg::Q_W-1:0]     dq_reg;     // dividend bits out, quotient in
    logic [pli_pkg::Q_W-1:0]     quot_reg;
    logic                        done_reg;

    // shared adder
    logic [pli_pkg::ALU_W-1:0]   alu_a;
    logic [pli_pkg::ALU_W-1:0]   alu_b;
    logic                        alu_sub;
    logic [pli_pkg::ALU_W-1:0]   alu_sum;

    logic [pli_pkg::Q_W-1:0]     shifted;
    logic [pli_pkg::MAG_W-1:0]   hi_next;
    logic [pli_pkg::DATA_W-1:0]  lo_next;
    logic                        ge;

    assign shifted = {rem_reg, dq_reg[pli_pkg::Q_W-1]};

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            M_MUL:
            begin
                alu_a = {1'b0, hi_reg};
                alu_b = lo_reg[0] ? {1'b0, mag_reg} : '0;
            end
            M_DIV:
            begin
                alu_a   = {1'b0, shifted};
                alu_b   = {2'b00, span_reg};
                alu_sub = 1'b1;
            end
            M_RND:
            begin
                // 2*rem >= span rounds the quotient up
                alu_a   = {1'b0, rem_reg, 1'b0};
                alu_b   = {2'b00, span_reg};
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(pli_pkg::ALU_W-1){1'b0}}, alu_sub};
    assign ge      = ~alu_sum[pli_pkg::ALU_W-1];
    assign hi_next = alu_sum[pli_pkg::ALU_W-1:1];
    assign lo_next = {alu_sum[0], lo_reg[pli_pkg::DATA_W-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= (state_reg == M_RND);
            case (state_reg)
                M_IDLE:
                begin
                    if (op.start)
                    begin
                        mag_reg   <= op.mag;
                        span_reg  <= op.span;
                        hi_reg    <= '0;
                        lo_reg    <= op.dx;
                        cnt_reg   <= '0;
                        state_reg <= M_MUL;
                    end
                end
                M_MUL:
                begin
                    hi_reg <= hi_next;
                    lo_reg <= lo_next;
                    if (cnt_reg == pli_pkg::STEP_W'(pli_pkg::MUL_STEPS - 1))
                    begin
                        // product < span * 2^33, so its top 32 bits seed the remainder
                        rem_reg   <= hi_next[pli_pkg::MAG_W-1:1];
                        dq_reg    <= {hi_next[0], lo_next};
                        cnt_reg   <= '0;
                        state_reg <= M_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                M_DIV:
                begin
                    rem_reg <= ge ? alu_sum[pli_pkg::DATA_W-1:0]
                                  : shifted[pli_pkg::DATA_W-1:0];
                    dq_reg  <= {dq_reg[pli_pkg::Q_W-2:0], ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == pli_pkg::STEP_W'(pli_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= M_RND;
                    end
                end
                M_RND:
                begin
                    quot_reg  <= dq_reg + {{(pli_pkg::Q_W-1){1'b0}}, ge};
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule

// File: rtl/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator: breakpoint table, segment
// search sequencer and result register. Depends on pli_pkg, pli_if,
// pli_ram and pli_mdu.
//
//  channel | dir | payload                                        | request taken when
//  --------+-----+------------------------------------------------+-------------------
//  req     | in  | op, point_index, point_radius, point_value, x  | valid & ready
//  rsp     | out | value, status                                  | valid & ready
//  cfg     | in  | point_count                                    | valid & ready (always ready)
//
// A write request stores its entry when taken. An evaluate request reads the table one
// entry per cycle through the single RAM read port: entry 0 and the last entry for the
// bounds check, then one more per segment scanned; on a hit the shared mul/div adder runs
// 32 multiply + 33 divide + 1 rounding steps.
// req.ready is high only while the sequencer is idle; a finished result
// waits in the rsp register and the next request is taken meanwhile.
// Reset clears control state and point_count; the table is undefined until written.
module piecewise_linear_interpolator (
    input  logic  clk,
    input  logic  rst_n,
    pli_req_if.sink   req,
    pli_rsp_if.source rsp,
    pli_cfg_if.sink   cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET0,      // entry 0 arrives, fetch last entry
        S_GETLAST,   // last entry arrives, bounds check
        S_SCAN,      // entry idx arrives, test segment idx-1..idx
        S_PREP,      // form the mul/div operands
        S_CALC,      // wait for the mul/div unit
        S_FINISH     // hand the result to the rsp register
    } state_t;

    state_t                          state_reg;
    logic [pli_pkg::CNT_W-1:0]       count_reg;
    pli_pkg::fix_t                   x_reg;
    pli_pkg::fix_t                   prev_r_reg;
    pli_pkg::fix_t                   prev_v_reg;
    pli_pkg::fix_t                   cur_r_reg;
    pli_pkg::fix_t                   cur_v_reg;
    logic [pli_pkg::PTR_W-1:0]       idx_reg;
    pli_pkg::fix_t                   res_value_reg;
    logic [pli_pkg::STATUS_W-1:0]    res_status_reg;
    logic                            neg_reg;
    logic                            rsp_valid_reg;
    pli_pkg::fix_t                   rsp_value_reg;
    logic [pli_pkg::STATUS_W-1:0]    rsp_status_reg;

    logic                            req_fire;
    logic                            ram_we;
    logic [pli_pkg::PTR_W-1:0]       ram_raddr;
    logic [pli_pkg::ENTRY_W-1:0]     ram_rdata;
    pli_pkg::fix_t                   rd_r;
    pli_pkg::fix_t                   rd_v;
    logic [pli_pkg::CNT_W-1:0]       n_eff;
    logic [pli_pkg::CNT_W-1:0]       n_last;
    logic [pli_pkg::PTR_W-1:0]       last_idx;
    logic                            out_free;

    logic signed [pli_pkg::DATA_W:0] dv;
    logic signed [pli_pkg::DATA_W:0] dx_full;
    logic signed [pli_pkg::DATA_W:0] span_full;
    logic signed [pli_pkg::ALU_W-1:0] v0_ext;
    logic signed [pli_pkg::ALU_W-1:0] q_ext;
    logic signed [pli_pkg::ALU_W-1:0] sum_full;
    pli_pkg::fix_t                   sat_value;

    pli_pkg::mdu_op_t                mdu_op;
    pli_pkg::mdu_res_t               mdu_res;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid & req.ready;
    assign cfg.ready = 1'b1;

    // counts above capacity act as a full table
    assign n_eff    = (count_reg > pli_pkg::CNT_W'(pli_pkg::MAX_POINTS))
                      ? pli_pkg::CNT_W'(pli_pkg::MAX_POINTS) : count_reg;
    assign n_last   = n_eff - 1'b1;
    assign last_idx = n_last[pli_pkg::PTR_W-1:0];

    assign ram_we = req_fire && (req.op == pli_pkg::OP_WRITE)
                    && (int'(req.point_index) < pli_pkg::MAX_POINTS);

    always_comb
    begin
        case (state_reg)
            S_GET0:    ram_raddr = last_idx;
            S_GETLAST: ram_raddr = pli_pkg::PTR_W'(1);
            S_SCAN:    ram_raddr = idx_reg + 1'b1;
            default:   ram_raddr = '0;
        endcase
    end

    pli_ram #(
        .WIDTH (pli_pkg::ENTRY_W),
        .DEPTH (pli_pkg::MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pli_pkg::PTR_W'(req.point_index)),
        .wdata ({req.point_radius, req.point_value}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_r = ram_rdata[pli_pkg::ENTRY_W-1:pli_pkg::DATA_W];
    assign rd_v = ram_rdata[pli_pkg::DATA_W-1:0];

    // operands of the matched segment; x lies in [r0, r1] so dx <= span
    assign dv        = {cur_v_reg[pli_pkg::DATA_W-1], cur_v_reg}
                       - {prev_v_reg[pli_pkg::DATA_W-1], prev_v_reg};
    assign dx_full   = {x_reg[pli_pkg::DATA_W-1], x_reg}
                       - {prev_r_reg[pli_pkg::DATA_W-1], prev_r_reg};
    assign span_full = {cur_r_reg[pli_pkg::DATA_W-1], cur_r_reg}
                       - {prev_r_reg[pli_pkg::DATA_W-1], prev_r_reg};

    assign mdu_op.start = (state_reg == S_PREP);
    assign mdu_op.mag   = dv[pli_pkg::DATA_W] ? pli_pkg::MAG_W'(-dv) : pli_pkg::MAG_W'(dv);
    assign mdu_op.dx    = dx_full[pli_pkg::DATA_W-1:0];
    assign mdu_op.span  = span_full[pli_pkg::DATA_W-1:0];

    pli_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mdu_op),
        .res   (mdu_res)
    );

    // v0 +/- q, clamped to 32 bits
    assign v0_ext   = pli_pkg::ALU_W'(prev_v_reg);
    assign q_ext    = $signed({1'b0, mdu_res.quot});
    assign sum_full = neg_reg ? (v0_ext - q_ext) : (v0_ext + q_ext);

    always_comb
    begin
        if (sum_full[pli_pkg::ALU_W-1:pli_pkg::DATA_W-1] == '0
            || sum_full[pli_pkg::ALU_W-1:pli_pkg::DATA_W-1] == '1)
        begin
            sat_value = sum_full[pli_pkg::DATA_W-1:0];
        end
        else if (sum_full[pli_pkg::ALU_W-1])
        begin
            sat_value = {1'b1, {(pli_pkg::DATA_W-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(pli_pkg::DATA_W-1){1'b1}}};
        end
    end

    assign out_free = ~rsp_valid_reg | rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                count_reg <= cfg.point_count;
            end

            // a new result refills the register in the cycle the old one leaves
            if (state_reg == S_FINISH && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        x_reg         <= req.x;
                        res_value_reg <= '0;
                        if (req.op == pli_pkg::OP_WRITE)
                        begin
                            res_status_reg <= pli_pkg::ST_OK;
                            state_reg      <= S_FINISH;
                        end
                        else if (n_eff == '0)
                        begin
                            res_status_reg <= pli_pkg::ST_EMPTY;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            res_status_reg <= pli_pkg::ST_OK;
                            state_reg      <= S_GET0;
                        end
                    end
                end
                S_GET0:
                begin
                    prev_r_reg <= rd_r;
                    prev_v_reg <= rd_v;
                    state_reg  <= S_GETLAST;
                end
                S_GETLAST:
                begin
                    idx_reg <= pli_pkg::PTR_W'(1);
                    if (x_reg < prev_r_reg || x_reg > rd_r)
                    begin
                        res_status_reg <= pli_pkg::ST_OUTSIDE;
                        state_reg      <= S_FINISH;
                    end
                    else if (last_idx == '0)
                    begin
                        // single point: no segment to test
                        res_status_reg <= pli_pkg::ST_NOSEG;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (x_reg >= prev_r_reg && x_reg <= rd_r)
                    begin
                        cur_r_reg <= rd_r;
                        cur_v_reg <= rd_v;
                        if (prev_r_reg == rd_r)
                        begin
                            res_status_reg <= pli_pkg::ST_ZEROW;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_PREP;
                        end
                    end
                    else if (idx_reg == last_idx)
                    begin
                        // unsorted table
                        res_status_reg <= pli_pkg::ST_NOSEG;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        prev_r_reg <= rd_r;
                        prev_v_reg <= rd_v;
                        idx_reg    <= idx_reg + 1'b1;
                    end
                end
                S_PREP:
                begin
                    neg_reg   <= dv[pli_pkg::DATA_W];
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    if (mdu_res.done)
                    begin
                        res_value_reg  <= sat_value;
                        res_status_reg <= pli_pkg::ST_OK;
                        state_reg      <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        rsp_value_reg  <= res_value_reg;
                        rsp_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.value  = rsp_value_reg;
    assign rsp.status = rsp_status_reg;

endmodule

// File: tb/piecewise_linear_interpolator_test.sv
// Self-checking testbench for piecewise_linear_interpolator: breakpoint writes and
// evaluations against a scoreboard that predicts each response in fixed point.
// Depends on pli_pkg, pli_if and the interpolator RTL.
module piecewise_linear_interpolator_test;
    import pli_pkg::*;

    localparam int     HALF_PERIOD  = 4;
    localparam int     RESET_CYCLES = 8;
    localparam int     ITEMS        = 1650;
    localparam int     IDLE_PCT     = 34;    // per-cycle idle chance, both sides
    localparam int     HOLD_CYCLES  = 400;   // long response back-pressure
    localparam int     QUIET_LIMIT  = 4000;  // cycles with no handshake at all
    localparam int     DRAIN_CYCLES = 200;
    localparam int     MAX_REPORTS  = 40;
    localparam int     CNT_MAX      = (1 << CNT_W) - 1;
    localparam fix_t   FIX_HI       = 32'sh7FFF_FFFF;
    localparam fix_t   FIX_LO       = 32'sh8000_0000;
    // (2^32-1)/15: sixteen points spread exactly from FIX_LO to FIX_HI
    localparam longint RADIUS_STEP  = 64'sd286331153;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] point_index;
        fix_t             point_radius;
        fix_t             point_value;
        fix_t             x;
    } pli_item_t;

    typedef struct packed {
        fix_t                value;
        logic [STATUS_W-1:0] status;
    } pli_result_t;

    // Shadow table, point count and the queue of responses still owed.
    class interp_scoreboard;
        fix_t              radius_tab [MAX_POINTS];
        fix_t              value_tab  [MAX_POINTS];
        bit [CNT_W-1:0]    point_count;
        pli_result_t       expected_q [$];
        int                errors;
        int                checked;
        int                n_writes;
        int                n_evals;
        int                status_hits [8];

        task report(string what);
            errors++;
            // keep the log short if the block is badly broken
            if (errors <= MAX_REPORTS)
                $display("MISMATCH: %s", what);
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        function void set_count(bit [CNT_W-1:0] c);
            point_count = c;
        endfunction

        // v0 + (v1-v0)*(x-r0)/(r1-r0), quotient rounded half away from zero
        function fix_t blend(int i, fix_t xv);
            longint          r0;
            longint          v0;
            longint          dv;
            longint          total;
            longint unsigned span;
            longint unsigned dx;
            longint unsigned mag;
            longint unsigned quot;
            r0    = radius_tab[i];
            v0    = value_tab[i];
            dv    = longint'(value_tab[i + 1]) - v0;
            span  = longint'(radius_tab[i + 1]) - r0;
            dx    = longint'(xv) - r0;
            mag   = (dv < 0) ? -dv : dv;
            quot  = (mag * dx + span / 2) / span;
            total = (dv < 0) ? v0 - longint'(quot) : v0 + longint'(quot);
            if (total > longint'(FIX_HI))
                return FIX_HI;
            if (total < longint'(FIX_LO))
                return FIX_LO;
            return fix_t'(total);
        endfunction

        function pli_result_t evaluate(fix_t xv);
            pli_result_t r;
            int          n;
            bit          hit;
            r.value  = '0;
            r.status = ST_NOSEG;
            hit      = 1'b0;
            n = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
            if (n == 0)
                r.status = ST_EMPTY;
            else if (xv < radius_tab[0] || xv > radius_tab[n - 1])
                r.status = ST_OUTSIDE;
            else
                for (int i = 0; i + 1 < n && !hit; i++)
                    if (xv >= radius_tab[i] && xv <= radius_tab[i + 1])
                    begin
                        hit = 1'b1;
                        if (radius_tab[i] == radius_tab[i + 1])
                            r.status = ST_ZEROW;
                        else
                        begin
                            r.value  = blend(i, xv);
                            r.status = ST_OK;
                        end
                    end
            return r;
        endfunction

        function void note_request(pli_item_t item);
            pli_result_t r;
            r.value  = '0;
            r.status = ST_OK;
            if (item.op == OP_WRITE)
            begin
                // a 4-bit slot is always inside the 16-entry table
                radius_tab[item.point_index] = item.point_radius;
                value_tab[item.point_index]  = item.point_value;
                n_writes++;
            end
            else
            begin
                r = evaluate(item.x);
                status_hits[r.status]++;
                n_evals++;
            end
            expected_q = {expected_q, r};
        endfunction

        task check_response(fix_t got_value, logic [STATUS_W-1:0] got_status);
            pli_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("response with nothing pending: value %0d status %0d",
                                 got_value, got_status));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got_status !== want.status)
                report($sformatf("response %0d: status %0d, expected %0d",
                                 checked, got_status, want.status));
            if (got_value !== want.value)
                report($sformatf("response %0d: value %0d, expected %0d",
                                 checked, got_value, want.value));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pli_req_if req_ch();
    pli_rsp_if rsp_ch();
    pli_cfg_if cfg_ch();

    piecewise_linear_interpolator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    interp_scoreboard sb = new();

    bit steady_traffic;   // no idling on either side while set
    bit hold_request;     // asks the response side for one long hold-off
    int settings_used;
    int quiet_cycles;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic fix_t rand_fix();
        return fix_t'($urandom);
    endfunction

    // Drive one request at the falling edge; return once it has been taken.
    task automatic send_request(input pli_item_t item);
        @(negedge clk);
        while (!steady_traffic && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= item.op;
        req_ch.point_index  <= item.point_index;
        req_ch.point_radius <= item.point_radius;
        req_ch.point_value  <= item.point_value;
        req_ch.x            <= item.x;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(item);
    endtask

    task automatic release_request();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic write_point(input int slot, input fix_t radius, input fix_t value);
        pli_item_t item;
        item.op           = OP_WRITE;
        item.point_index  = slot[IDX_W-1:0];
        item.point_radius = radius;
        item.point_value  = value;
        item.x            = rand_fix();   // don't-care on a write
        send_request(item);
    endtask

    task automatic evaluate_at(input fix_t xv);
        pli_item_t item;
        item.op           = OP_EVAL;
        item.point_index  = IDX_W'($urandom_range(0, MAX_POINTS - 1));
        item.point_radius = rand_fix();
        item.point_value  = rand_fix();
        item.x            = xv;
        send_request(item);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // The count only changes with the block idle: no request offered and every
    // response already back (each request yields exactly one response).
    task automatic write_point_count(input bit [CNT_W-1:0] c);
        release_request();
        wait_drained();
        @(negedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.point_count <= c;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_count(c);
        settings_used++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One random setting: pick a count, load a table of some shape, then
    // evaluate mostly inside the table span with some noise mixed in.
    task automatic random_phase(input bit squeeze, input bit long_phase);
        bit [CNT_W-1:0]  cnt;
        int              used;
        int              style;
        int              evals;
        int              pick;
        int              radii [];
        fix_t            lo;
        fix_t            hi;
        fix_t            ordinate;
        longint unsigned width;
        longint unsigned rnd;
        case ($urandom_range(0, 9))
            0:       cnt = CNT_W'(0);
            1:       cnt = CNT_W'(1);
            2:       cnt = CNT_W'(2);
            3:       cnt = CNT_W'(MAX_POINTS);
            4:       cnt = CNT_W'($urandom_range(MAX_POINTS + 1, CNT_MAX));
            default: cnt = CNT_W'($urandom_range(2, MAX_POINTS));
        endcase
        write_point_count(cnt);
        if (squeeze)
            hold_request = 1'b1;
        used  = (cnt > MAX_POINTS) ? MAX_POINTS : int'(cnt);
        style = $urandom_range(0, 9);
        radii = new[used];

        // styles: 0-4 wide sorted, 5 sorted with repeats, 6 unsorted,
        // 7 narrow strictly rising, 8 narrow with repeats, 9 full-range ends
        if (style == 7 || style == 8)
        begin
            if (used > 0)
                radii[0] = int'($urandom_range(0, 32'hFFFF_FF00) ^ 32'h8000_0000);
            for (int j = 1; j < used; j++)
                radii[j] = radii[j - 1] + int'($urandom_range(style - 7 ? 0 : 1, 8));
        end
        else
        begin
            for (int j = 0; j < used; j++)
                radii[j] = int'($urandom);
            if (style != 6)
                radii.sort();
            if (style == 5)
                for (int j = 1; j < used; j++)
                    if ($urandom_range(0, 3) == 0)
                        radii[j] = radii[j - 1];
            if (style == 9 && used > 0)
            begin
                radii[0]        = FIX_LO;
                radii[used - 1] = FIX_HI;
            end
        end

        for (int j = 0; j < used; j++)
        begin
            case ($urandom_range(0, 7))
                0:       ordinate = $urandom_range(0, 1) ? FIX_HI : FIX_LO;
                1, 2:    ordinate = int'($urandom_range(0, 32)) - 16;   // rounding ties
                default: ordinate = rand_fix();
            endcase
            write_point(j, radii[j], ordinate);
        end

        evals = long_phase ? 40 : $urandom_range(10, 30);
        for (int k = 0; k < evals; k++)
        begin
            pick = $urandom_range(0, 99);
            lo   = sb.radius_tab[0];
            hi   = sb.radius_tab[(used > 0) ? used - 1 : 0];
            if (used == 0 || pick < 10)
                evaluate_at(rand_fix());
            else if (pick < 18)
                write_point($urandom_range(0, MAX_POINTS - 1), rand_fix(), rand_fix());
            else if (pick < 30)
                // on a breakpoint or one step either side of it
                evaluate_at(sb.radius_tab[$urandom_range(0, used - 1)]
                            + int'($urandom_range(0, 2)) - 1);
            else if (pick < 36)
                evaluate_at(pick[0] ? hi + 1 : lo - 1);
            else if (lo > hi)
                evaluate_at(rand_fix());
            else
            begin
                width = longint'(hi) - longint'(lo);
                rnd   = {$urandom, $urandom};
                evaluate_at(fix_t'(longint'(lo) + longint'(rnd % (width + 1))));
            end
        end
    endtask

    // Response side: random ready, one long hold-off on request, none while steady.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            else
                rsp_ch.ready <= steady_traffic || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
        if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.value, rsp_ch.status);

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles, %0d responses pending",
                     QUIET_LIMIT, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int phase_no;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_WRITE;
        req_ch.point_index  = '0;
        req_ch.point_radius = '0;
        req_ch.point_value  = '0;
        req_ch.x            = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.point_count  = '0;
        steady_traffic      = 1'b0;
        hold_request        = 1'b0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Fill every slot first so no evaluation can ever read
        // an unwritten entry: radii span the whole range, values alternate
        // between the two extremes (largest possible slope magnitudes).
        for (int i = 0; i < MAX_POINTS; i++)
            write_point(i, fix_t'(longint'(i) * RADIUS_STEP - 64'sd2147483648),
                        i[0] ? FIX_HI : FIX_LO);
        evaluate_at(FIX_LO);                    // count still 0: empty table
        write_point_count(CNT_W'(MAX_POINTS));
        evaluate_at(FIX_LO);                    // lowest x, left end of first segment
        evaluate_at(FIX_HI);                    // highest x, right end of last segment
        evaluate_at('0);
        evaluate_at(sb.radius_tab[3]);          // exactly on a breakpoint
        evaluate_at(sb.radius_tab[3] + 1);
        write_point_count(CNT_W'(1));
        evaluate_at(FIX_LO);                    // single point: no segment
        evaluate_at('0);                        // beyond the only point: outside
        write_point(1, FIX_LO, 32'sd12345);
        write_point_count(CNT_W'(2));
        evaluate_at(FIX_LO);                    // zero-width first segment
        write_point_count(CNT_W'(CNT_MAX));     // above capacity, acts as full table
        evaluate_at(FIX_HI);

        // Random part; one setting runs without idling, a later one gets the
        // long response hold-off so the block backs up into its input.
        phase_no = 0;
        while (sb.n_writes + sb.n_evals < ITEMS)
        begin
            steady_traffic = (phase_no == 3);
            random_phase(phase_no == 6, phase_no == 3 || phase_no == 6);
            phase_no++;
        end
        steady_traffic = 1'b0;

        release_request();
        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Ran %0d breakpoint writes and %0d evaluations over %0d point-count settings.",
                 sb.n_writes, sb.n_evals, settings_used);
        $display("Evaluations: %0d ok, %0d outside, %0d empty, %0d no segment, %0d zero width.",
                 sb.status_hits[ST_OK], sb.status_hits[ST_OUTSIDE], sb.status_hits[ST_EMPTY],
                 sb.status_hits[ST_NOSEG], sb.status_hits[ST_ZEROW]);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
